/* rtl/qte_pkg.sv */
// Package for the quaternion to Euler angle converter.
// Shared widths, payload types, CORDIC angle table and default parameters.
// Depends on nothing.
package qte_pkg;

	localparam int CORDIC_STEPS_DEF    = 16;
	localparam int ANGLE_FRAC_BITS_DEF = 13;

	localparam int TERM_W = 34;   // sine/cosine terms, 28 fraction bits
	localparam int XY_W   = 37;   // CORDIC x and y
	localparam int Z_W    = 36;   // CORDIC angle, 30 fraction bits
	localparam int RAD_W  = 58;   // radicand padded to an even bit count
	localparam int REM_W  = 31;
	localparam int ROOT_W = 29;
	localparam int SQRT_STAGES = RAD_W / 2;

	typedef struct packed {
		logic signed [TERM_W-1:0] sr;
		logic signed [TERM_W-1:0] cr;
		logic signed [TERM_W-1:0] sy;
		logic signed [TERM_W-1:0] cy;
		logic signed [TERM_W-1:0] sp;
		logic                     clamp;
	} qte_terms_t;

	typedef struct packed {
		logic [15:0] roll;
		logic [14:0] pitch;
		logic [15:0] yaw;
		logic        clamp;
	} qte_res_t;

	// atan(2^-i) in 30 fraction bits, truncated
	function automatic logic [31:0] atan_q30(input int i);
		logic [31:0] t;
		begin
			unique case (i)
				0: t = 32'h3243F6A8;
				1: t = 32'h1DAC6705;
				2: t = 32'h0FADBAFC;
				3: t = 32'h07F56EA6;
				4: t = 32'h03FEAB76;
				5: t = 32'h01FFD55B;
				6: t = 32'h00FFFAAA;
				7: t = 32'h007FFF55;
				8: t = 32'h003FFFEA;
				9: t = 32'h001FFFFD;
				10: t = 32'h000FFFFF;
				11: t = 32'h0007FFFF;
				12: t = 32'h0003FFFF;
				13: t = 32'h0001FFFF;
				14: t = 32'h0000FFFF;
				15: t = 32'h00007FFF;
				16: t = 32'h00003FFF;
				17: t = 32'h00001FFF;
				18: t = 32'h00000FFF;
				19: t = 32'h000007FF;
				20: t = 32'h000003FF;
				21: t = 32'h000001FF;
				22: t = 32'h000000FF;
				23: t = 32'h0000007F;
				default: t = 32'h0;
			endcase
			return t;
		end
	endfunction

endpackage

/* rtl/qte_fifo.sv */
// Two-entry register queue used between the front, the back and the result port.
// Depends on nothing.
module qte_fifo #(
	parameter int W = 8
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  logic [W-1:0] wdata,
	output logic         full,
	input  logic         pop,
	output logic [W-1:0] rdata,
	output logic         empty
);
	logic [W-1:0] mem_q [2];
	logic         wp_q, rp_q;
	logic [1:0]   cnt_q;
	logic         do_wr, do_rd;

	assign full  = (cnt_q == 2'd2);
	assign empty = (cnt_q == 2'd0);
	assign do_wr = push && !full;
	assign do_rd = pop && !empty;
	assign rdata = mem_q[rp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (do_wr) wp_q <= !wp_q;
			if (do_rd) rp_q <= !rp_q;
			cnt_q <= cnt_q + {1'b0, do_wr} - {1'b0, do_rd};
		end
	end

	always_ff @(posedge clk) begin
		if (do_wr) mem_q[wp_q] <= wdata;
	end
endmodule

/* rtl/qte_front.sv */
// Front end: takes quaternions, forms the products and the sine/cosine terms,
// classifies the pitch clamp case. Depends on qte_pkg.
module qte_front
	import qte_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	output logic              full,
	input  logic signed [15:0] quat_w,
	input  logic signed [15:0] quat_x,
	input  logic signed [15:0] quat_y,
	input  logic signed [15:0] quat_z,
	output logic              mid_push,
	output qte_terms_t        mid_data,
	input  logic              mid_full
);
	logic signed [15:0] w_s1, x_s1, y_s1, z_s1;
	logic signed [31:0] wx_s2, yz_s2, xx_s2, yy_s2, wz_s2, xy_s2, zz_s2, wy_s2, zx_s2;
	qte_terms_t         t_s3;
	logic               v_s1, v_s2, v_s3;
	logic               adv;
	logic signed [TERM_W-1:0] sr, cr, sy, cy, sp;

	localparam logic signed [TERM_W-1:0] ONE_Q28 = TERM_W'(1) <<< 28;

	// hold every stage while the last one cannot hand over
	assign adv      = !(v_s3 && mid_full);
	assign full     = !adv;
	assign mid_push = v_s3 && !mid_full;
	assign mid_data = t_s3;

	always_comb begin
		sr = (TERM_W'(wx_s2) + TERM_W'(yz_s2)) <<< 1;
		cr = ONE_Q28 - ((TERM_W'(xx_s2) + TERM_W'(yy_s2)) <<< 1);
		sy = (TERM_W'(wz_s2) + TERM_W'(xy_s2)) <<< 1;
		cy = ONE_Q28 - ((TERM_W'(yy_s2) + TERM_W'(zz_s2)) <<< 1);
		sp = (TERM_W'(wy_s2) - TERM_W'(zx_s2)) <<< 1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (adv) begin
			v_s1 <= push;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			w_s1  <= quat_w;
			x_s1  <= quat_x;
			y_s1  <= quat_y;
			z_s1  <= quat_z;
			wx_s2 <= w_s1 * x_s1;
			yz_s2 <= y_s1 * z_s1;
			xx_s2 <= x_s1 * x_s1;
			yy_s2 <= y_s1 * y_s1;
			wz_s2 <= w_s1 * z_s1;
			xy_s2 <= x_s1 * y_s1;
			zz_s2 <= z_s1 * z_s1;
			wy_s2 <= w_s1 * y_s1;
			zx_s2 <= z_s1 * x_s1;
			t_s3.sr    <= sr;
			t_s3.cr    <= cr;
			t_s3.sy    <= sy;
			t_s3.cy    <= cy;
			t_s3.sp    <= sp;
			t_s3.clamp <= (sp >= ONE_Q28) || (sp <= -ONE_Q28);
		end
	end
endmodule

/* rtl/qte_back.sv */
// Back end: pipelined square root for the pitch cosine, three CORDIC vectoring
// lanes (roll, pitch, yaw), rounding and saturation. Depends on qte_pkg.
module qte_back
	import qte_pkg::*;
#(
	parameter int CORDIC_STEPS    = CORDIC_STEPS_DEF,
	parameter int ANGLE_FRAC_BITS = ANGLE_FRAC_BITS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  qte_terms_t mid_data,
	input  logic       mid_empty,
	output logic       mid_pop,
	output logic       res_push,
	output qte_res_t   res_data,
	input  logic       res_full
);
	typedef struct packed {
		qte_terms_t        t;
		logic [RAD_W-1:0]  rad;
		logic [REM_W-1:0]  rem;
		logic [ROOT_W-1:0] root;
	} sq_t;

	typedef struct packed {
		logic signed [XY_W-1:0] x;
		logic signed [XY_W-1:0] y;
		logic signed [Z_W-1:0]  z;
		logic                   zero;
	} lane_t;

	typedef struct packed {
		lane_t [2:0] ln;   // 0 roll, 1 pitch, 2 yaw
		logic        clamp;
		logic        neg;
	} cs_t;

	localparam int LAT = 1 + SQRT_STAGES + 1 + CORDIC_STEPS + 1;
	localparam int SH  = 30 - ANGLE_FRAC_BITS;
	localparam logic signed [Z_W-1:0] PI_Q30 = 36'sh0C90FDAA2;
	localparam logic signed [Z_W-1:0] PI_F   = (PI_Q30 + (Z_W'(1) <<< (SH - 1))) >>> SH;
	localparam logic signed [Z_W-1:0] HP_F   = (PI_Q30 + (Z_W'(1) <<< SH)) >>> (SH + 1);
	localparam logic [RAD_W-2:0]      ONE56  = (RAD_W-1)'(1) << 56;

	logic [LAT-1:0] v_s;
	logic           adv;

	qte_terms_t  t_s1;
	logic [55:0] mag2_s1;
	logic signed [TERM_W-1:0] sp_abs;
	logic [27:0] mag;

	sq_t sq_in;
	sq_t sq_s  [1:SQRT_STAGES];
	sq_t sq_nx [0:SQRT_STAGES-1];
	cs_t cs_in;
	cs_t cs_s  [0:CORDIC_STEPS];
	cs_t cs_nx [0:CORDIC_STEPS-1];
	qte_res_t res_s;
	qte_res_t res_nx;

	function automatic sq_t sqrt_step(input sq_t s, input int k);
		sq_t                 o;
		logic [REM_W+1:0]    t;
		logic [REM_W+1:0]    trial;
		begin
			o     = s;
			t     = {s.rem, s.rad[RAD_W-1-2*k -: 2]};
			trial = (REM_W+2)'({s.root, 2'b01});
			if (t >= trial) begin
				o.rem  = REM_W'(t - trial);
				o.root = {s.root[ROOT_W-2:0], 1'b1};
			end else begin
				o.rem  = REM_W'(t);
				o.root = {s.root[ROOT_W-2:0], 1'b0};
			end
			return o;
		end
	endfunction

	function automatic lane_t lane_init(input logic signed [XY_W-1:0] y,
		input logic signed [XY_W-1:0] x);
		lane_t o;
		begin
			o.zero = (x == '0) && (y == '0);
			if (x < 0) begin
				o.x = -x;
				o.y = -y;
				o.z = (y >= 0) ? PI_Q30 : -PI_Q30;
			end else begin
				o.x = x;
				o.y = y;
				o.z = '0;
			end
			return o;
		end
	endfunction

	function automatic lane_t lane_step(input lane_t l, input int i);
		lane_t                  o;
		logic signed [XY_W-1:0] xs, ys;
		logic signed [Z_W-1:0]  a;
		begin
			o  = l;
			xs = l.x >>> i;
			ys = l.y >>> i;
			a  = signed'(Z_W'(atan_q30(i)));
			if (!l.y[XY_W-1]) begin
				o.x = l.x + ys;
				o.y = l.y - xs;
				o.z = l.z + a;
			end else begin
				o.x = l.x - ys;
				o.y = l.y + xs;
				o.z = l.z - a;
			end
			return o;
		end
	endfunction

	function automatic logic signed [Z_W-1:0] finish(input lane_t l,
		input logic signed [Z_W-1:0] lim);
		logic signed [Z_W-1:0] r;
		begin
			r = (l.z + (Z_W'(1) <<< (SH - 1))) >>> SH;
			if (r > lim) r = lim;
			if (r < -lim) r = -lim;
			if (l.zero) r = '0;
			return r;
		end
	endfunction

	// the whole back pipeline moves together; it stops only when a result cannot leave
	assign adv      = !(v_s[LAT-1] && res_full);
	assign mid_pop  = adv && !mid_empty;
	assign res_push = v_s[LAT-1] && !res_full;
	assign res_data = res_s;

	assign sp_abs = mid_data.sp[TERM_W-1] ? -mid_data.sp : mid_data.sp;
	assign mag    = sp_abs[27:0];

	always_comb begin
		sq_in.t    = t_s1;
		sq_in.rad  = {1'b0, ONE56 - {1'b0, mag2_s1}};
		sq_in.rem  = '0;
		sq_in.root = '0;
		sq_nx[0]   = sqrt_step(sq_in, 0);
		for (int k = 1; k < SQRT_STAGES; k++) sq_nx[k] = sqrt_step(sq_s[k], k);
	end

	always_comb begin
		cs_in.ln[0] = lane_init(XY_W'(sq_s[SQRT_STAGES].t.sr), XY_W'(sq_s[SQRT_STAGES].t.cr));
		cs_in.ln[1] = lane_init(XY_W'(sq_s[SQRT_STAGES].t.sp),
			signed'({(XY_W-ROOT_W)'(0), sq_s[SQRT_STAGES].root}));
		cs_in.ln[2] = lane_init(XY_W'(sq_s[SQRT_STAGES].t.sy), XY_W'(sq_s[SQRT_STAGES].t.cy));
		cs_in.clamp = sq_s[SQRT_STAGES].t.clamp;
		cs_in.neg   = sq_s[SQRT_STAGES].t.sp[TERM_W-1];
		for (int i = 0; i < CORDIC_STEPS; i++) begin
			cs_nx[i] = cs_s[i];
			for (int j = 0; j < 3; j++) cs_nx[i].ln[j] = lane_step(cs_s[i].ln[j], i);
		end
	end

	always_comb begin
		logic signed [Z_W-1:0] rr, pp, yy;
		rr = finish(cs_s[CORDIC_STEPS].ln[0], PI_F);
		pp = finish(cs_s[CORDIC_STEPS].ln[1], HP_F);
		yy = finish(cs_s[CORDIC_STEPS].ln[2], PI_F);
		if (cs_s[CORDIC_STEPS].clamp) pp = cs_s[CORDIC_STEPS].neg ? -HP_F : HP_F;
		res_nx.roll  = rr[15:0];
		res_nx.pitch = pp[14:0];
		res_nx.yaw   = yy[15:0];
		res_nx.clamp = cs_s[CORDIC_STEPS].clamp;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s <= '0;
		end else if (adv) begin
			v_s <= {v_s[LAT-2:0], !mid_empty};
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			t_s1    <= mid_data;
			mag2_s1 <= mag * mag;
			for (int k = 1; k <= SQRT_STAGES; k++) sq_s[k] <= sq_nx[k-1];
			cs_s[0] <= cs_in;
			for (int i = 1; i <= CORDIC_STEPS; i++) cs_s[i] <= cs_nx[i-1];
			res_s <= res_nx;
		end
	end
endmodule

/* rtl/quaternion_to_euler.sv */
// Top level of the quaternion to Euler angle converter.
// Depends on qte_pkg, qte_front, qte_fifo and qte_back.
//
//   channel   handshake        payload
//   input     push / full      quat_w, quat_x, quat_y, quat_z  (Q1.14)
//   result    empty / pop      roll_angle, yaw_angle (Q2.13), pitch_angle (Q1.13), pitch_clamped
//
// One item per cycle sustained while the result port is not stalled. From accept to
// result the request passes 3 front stages (input, product, term), the mid queue,
// the square stage, 29 square-root stages, the CORDIC setup stage, the CORDIC_STEPS
// vectoring stages, the rounding stage and the output queue, the first loaded at the
// accepting edge.
// Reset clears only the valid bits and the queue pointers and counts.
// A stalled result port stops the back pipeline; the front then fills the mid queue.
module quaternion_to_euler
	import qte_pkg::*;
#(
	parameter int CORDIC_STEPS    = CORDIC_STEPS_DEF,
	parameter int ANGLE_FRAC_BITS = ANGLE_FRAC_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	output logic               full,
	input  logic signed [15:0] quat_w,
	input  logic signed [15:0] quat_x,
	input  logic signed [15:0] quat_y,
	input  logic signed [15:0] quat_z,
	output logic               empty,
	input  logic               pop,
	output logic signed [15:0] roll_angle,
	output logic signed [14:0] pitch_angle,
	output logic signed [15:0] yaw_angle,
	output logic               pitch_clamped
);
	qte_terms_t f_data, m_data;
	logic       f_push, m_full, m_empty, m_pop;
	qte_res_t   r_data, o_data;
	logic       r_push, r_full;

	qte_front u_front (
		.clk, .arst_n, .push, .full, .quat_w, .quat_x, .quat_y, .quat_z,
		.mid_push(f_push), .mid_data(f_data), .mid_full(m_full)
	);

	qte_fifo #(.W($bits(qte_terms_t))) u_mid (
		.clk, .arst_n, .push(f_push), .wdata(f_data), .full(m_full),
		.pop(m_pop), .rdata(m_data), .empty(m_empty)
	);

	qte_back #(.CORDIC_STEPS(CORDIC_STEPS), .ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)) u_back (
		.clk, .arst_n, .mid_data(m_data), .mid_empty(m_empty), .mid_pop(m_pop),
		.res_push(r_push), .res_data(r_data), .res_full(r_full)
	);

	qte_fifo #(.W($bits(qte_res_t))) u_out (
		.clk, .arst_n, .push(r_push), .wdata(r_data), .full(r_full),
		.pop, .rdata(o_data), .empty
	);

	assign roll_angle    = o_data.roll;
	assign pitch_angle   = o_data.pitch;
	assign yaw_angle     = o_data.yaw;
	assign pitch_clamped = o_data.clamp;
endmodule

/* bench/tb_quaternion_to_euler.sv */
// Self-checking bench for quaternion_to_euler: directed table, then random phases.
// Depends on qte_pkg and the quaternion_to_euler RTL; results are predicted in-bench.
module tb_quaternion_to_euler;
	import qte_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int     STEPS      = 16;
	localparam int     FRAC       = 13;
	localparam int     WDOG_LIMIT = 5000;
	localparam int     HOLD_LEN   = 400;
	localparam int     RAND_ITEMS = 1300;
	localparam longint ONE_Q28    = 64'sd1 <<< 28;
	localparam longint PI_Q30     = 64'sh0C90FDAA2;
	localparam longint PI_LIM     = (PI_Q30 + (64'sd1 <<< (29 - FRAC))) >>> (30 - FRAC);
	localparam longint HALF_LIM   = (PI_Q30 + (64'sd1 <<< (30 - FRAC))) >>> (31 - FRAC);

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               push = 1'b0;
	logic               full;
	logic signed [15:0] quat_w = '0, quat_x = '0, quat_y = '0, quat_z = '0;
	logic               empty;
	logic               pop = 1'b0;
	logic signed [15:0] roll_angle;
	logic signed [14:0] pitch_angle;
	logic signed [15:0] yaw_angle;
	logic               pitch_clamped;

	quaternion_to_euler u_dut (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full),
		.quat_w(quat_w), .quat_x(quat_x), .quat_y(quat_y), .quat_z(quat_z),
		.empty(empty), .pop(pop), .roll_angle(roll_angle), .pitch_angle(pitch_angle),
		.yaw_angle(yaw_angle), .pitch_clamped(pitch_clamped)
	);

	always #1 clk = ~clk;

	typedef struct {
		logic signed [15:0] w, x, y, z;
		bit                 typed;     // pitch and flag given directly
		logic signed [14:0] pitch;
		logic               clamp;
	} quat_row_t;

	qte_res_t  angles_due[$];
	qte_res_t  typed_due[$];          // per-request override, queued with the request
	bit        typed_flag[$];
	int        errors = 0;
	int        n_sent = 0, n_recv = 0, n_clamp = 0;
	int        send_idle = 0, recv_idle = 0;
	bit        hold_req = 1'b0;
	bit        stim_done = 1'b0;
	int        quiet = 0;

	function automatic longint atan_entry(input int i);
		longint t [24] = '{
			'h3243F6A8, 'h1DAC6705, 'h0FADBAFC, 'h07F56EA6, 'h03FEAB76, 'h01FFD55B,
			'h00FFFAAA, 'h007FFF55, 'h003FFFEA, 'h001FFFFD, 'h000FFFFF, 'h0007FFFF,
			'h0003FFFF, 'h0001FFFF, 'h0000FFFF, 'h00007FFF, 'h00003FFF, 'h00001FFF,
			'h00000FFF, 'h000007FF, 'h000003FF, 'h000001FF, 'h000000FF, 'h0000007F};
		return t[i];
	endfunction

	function automatic longint vector_angle(input longint sv, input longint cv,
			input longint lim);
		longint ang, xs, ys, r;
		ang = 0;
		if (sv == 0 && cv == 0)
			return 0;
		if (cv < 0) begin
			ang = (sv >= 0) ? PI_Q30 : -PI_Q30;
			cv = -cv;
			sv = -sv;
		end
		for (int i = 0; i < STEPS && i < 24; i++) begin
			xs = cv >>> i;
			ys = sv >>> i;
			if (sv >= 0) begin
				cv += ys;
				sv -= xs;
				ang += atan_entry(i);
			end else begin
				cv -= ys;
				sv += xs;
				ang -= atan_entry(i);
			end
		end
		r = (ang + (64'sd1 <<< (29 - FRAC))) >>> (30 - FRAC);
		if (r > lim)
			r = lim;
		if (r < -lim)
			r = -lim;
		return r;
	endfunction

	function automatic longint unsigned floor_sqrt(input longint unsigned v);
		longint unsigned res, b;
		res = 0;
		b = 64'd1 << 62;
		while (b > v)
			b >>= 2;
		while (b != 0) begin
			if (v >= res + b) begin
				v -= res + b;
				res = (res >> 1) + b;
			end else begin
				res >>= 1;
			end
			b >>= 2;
		end
		return res;
	endfunction

	function automatic qte_res_t euler_of(input logic signed [15:0] qw, qx, qy, qz);
		longint w, x, y, z, sr, cr, sy, cy, sp, p, c;
		longint unsigned mag;
		qte_res_t r;
		w = qw; x = qx; y = qy; z = qz;
		sr = 2 * (w * x + y * z);
		cr = ONE_Q28 - 2 * (x * x + y * y);
		sy = 2 * (w * z + x * y);
		cy = ONE_Q28 - 2 * (y * y + z * z);
		sp = 2 * (w * y - z * x);
		r.roll = 16'(vector_angle(sr, cr, PI_LIM));
		r.yaw = 16'(vector_angle(sy, cy, PI_LIM));
		if (sp >= ONE_Q28 || sp <= -ONE_Q28) begin
			p = (sp > 0) ? HALF_LIM : -HALF_LIM;
			r.clamp = 1'b1;
		end else begin
			mag = (sp < 0) ? -sp : sp;
			c = longint'(floor_sqrt((64'd1 << 56) - mag * mag));
			p = vector_angle(sp, c, HALF_LIM);
			r.clamp = 1'b0;
		end
		r.pitch = 15'(p);
		return r;
	endfunction

	// accept monitor, scoreboard and watchdog
	always @(posedge clk) begin
		qte_res_t e;
		bit moved;
		moved = 1'b0;
		if (arst_n && push && !full) begin
			e = euler_of(quat_w, quat_x, quat_y, quat_z);
			if (typed_flag.size() != 0) begin
				if (typed_flag.pop_front()) begin
					e.pitch = typed_due[0].pitch;
					e.clamp = typed_due[0].clamp;
				end
				void'(typed_due.pop_front());
			end
			angles_due.insert(angles_due.size(), e);
			n_sent++;
			moved = 1'b1;
		end
		if (arst_n && pop && !empty) begin
			moved = 1'b1;
			n_recv++;
			if (angles_due.size() == 0) begin
				$error("result with no request pending");
				errors++;
			end else begin
				e = angles_due.pop_front();
				if (pitch_clamped) n_clamp++;
				if (roll_angle !== e.roll) begin
					$error("roll_angle exp %0d got %0d", $signed(e.roll), roll_angle);
					errors++;
				end
				if (pitch_angle !== e.pitch) begin
					$error("pitch_angle exp %0d got %0d", $signed(e.pitch), pitch_angle);
					errors++;
				end
				if (yaw_angle !== e.yaw) begin
					$error("yaw_angle exp %0d got %0d", $signed(e.yaw), yaw_angle);
					errors++;
				end
				if (pitch_clamped !== e.clamp) begin
					$error("pitch_clamped exp %0b got %0b", e.clamp, pitch_clamped);
					errors++;
				end
			end
		end
		quiet = moved ? 0 : quiet + 1;
		if (arst_n && quiet >= WDOG_LIMIT) begin
			$display("watchdog expired");
			$display("Some tests failed");
			$finish;
		end
	end

	// result side: random stall, or a long hold while the sender floods
	always @(posedge clk) begin
		if (hold_req) begin
			pop <= 1'b0;
			repeat (HOLD_LEN - 1) @(posedge clk);
			hold_req = 1'b0;
		end else begin
			pop <= ($urandom_range(99) >= recv_idle);
		end
	end

	task automatic send(input logic signed [15:0] w, x, y, z);
		while ($urandom_range(99) < send_idle) begin
			push <= 1'b0;
			@(posedge clk);
		end
		push <= 1'b1;
		quat_w <= w; quat_x <= x; quat_y <= y; quat_z <= z;
		do @(posedge clk); while (full);
	endtask

	function automatic logic signed [15:0] unit_part();
		return 16'($signed($urandom_range(32768)) - 16384);
	endfunction

	quat_row_t plan [] = '{
		'{16'sd0, 16'sd0, 16'sd0, 16'sd0, 1'b1, 15'sd0, 1'b0},
		'{16'sd16384, 16'sd0, 16'sd0, 16'sd0, 1'b0, 15'sd0, 1'b0},
		'{16'sd16384, 16'sd0, 16'sd16384, 16'sd0, 1'b1, 15'sd12868, 1'b1},
		'{16'sd16384, 16'sd0, -16'sd16384, 16'sd0, 1'b1, -15'sd12868, 1'b1},
		'{-16'sd32768, 16'sd0, 16'sd32767, 16'sd0, 1'b1, -15'sd12868, 1'b1},
		'{16'sd32767, 16'sd0, 16'sd32767, 16'sd0, 1'b1, 15'sd12868, 1'b1},
		'{-16'sd32768, -16'sd32768, -16'sd32768, -16'sd32768, 1'b0, 15'sd0, 1'b0},
		'{16'sd32767, 16'sd32767, 16'sd32767, 16'sd32767, 1'b0, 15'sd0, 1'b0},
		'{16'sd32767, -16'sd32768, 16'sd32767, -16'sd32768, 1'b0, 15'sd0, 1'b0},
		// sine zero, cosine negative: angle starts at +pi
		'{16'sd0, 16'sd16384, 16'sd0, 16'sd0, 1'b0, 15'sd0, 1'b0},
		'{16'sd0, 16'sd0, 16'sd0, 16'sd16384, 1'b0, 15'sd0, 1'b0},
		// negative sine in left half plane
		'{-16'sd100, 16'sd16000, 16'sd0, 16'sd0, 1'b0, 15'sd0, 1'b0},
		// roll vector is exactly zero
		'{16'sd1, 16'sd8192, 16'sd8192, -16'sd1, 1'b0, 15'sd0, 1'b0},
		'{16'sd11585, 16'sd0, 16'sd11585, 16'sd0, 1'b0, 15'sd0, 1'b0},
		'{16'sd11585, 16'sd0, 16'sd11586, 16'sd0, 1'b0, 15'sd0, 1'b0},
		'{16'sd11585, 16'sd11585, 16'sd0, 16'sd0, 1'b0, 15'sd0, 1'b0},
		'{16'sd8192, 16'sd8192, 16'sd8192, 16'sd8192, 1'b0, 15'sd0, 1'b0},
		'{16'sd1, -16'sd1, 16'sd1, -16'sd1, 1'b0, 15'sd0, 1'b0}
	};

	initial begin
		int idle_s [4] = '{0, 80, 0, 27};
		int idle_r [4] = '{0, 0, 80, 27};
		qte_res_t t;
		int pick;
		logic signed [15:0] a, b;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (plan[i]) begin
			t.pitch = plan[i].pitch;
			t.clamp = plan[i].clamp;
			typed_due.insert(typed_due.size(), t);
			typed_flag.insert(typed_flag.size(), plan[i].typed);
			send(plan[i].w, plan[i].x, plan[i].y, plan[i].z);
		end
		for (int ph = 0; ph < 4; ph++) begin
			send_idle = idle_s[ph];
			recv_idle = idle_r[ph];
			if (ph == 0)
				hold_req = 1'b1;
			for (int n = 0; n < RAND_ITEMS / 4; n++) begin
				pick = $urandom_range(9);
				typed_due.insert(typed_due.size(), t);
				typed_flag.insert(typed_flag.size(), 1'b0);
				if (pick < 3) begin
					send(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
				end else if (pick < 7) begin
					send(unit_part(), unit_part(), unit_part(), unit_part());
				end else begin
					// w close to +-y or z close to -+x drives the pitch sine toward one
					a = unit_part();
					b = unit_part();
					send(a, b, $urandom_range(1) ? a + 16'($urandom_range(8)) : -a,
						$urandom_range(1) ? -b : b);
				end
				if (ph == 3 && (n % 40) < 10) begin
					send_idle = 0;
					recv_idle = 0;
				end else begin
					send_idle = idle_s[ph];
					recv_idle = idle_r[ph];
				end
			end
		end
		push <= 1'b0;
		recv_idle = 0;
		stim_done = 1'b1;
		while (angles_due.size() != 0)
			@(posedge clk);
		repeat (80) @(posedge clk);
		$display("Sent %0d quaternions, checked %0d angle sets (%0d pitch clamps),",
			n_sent, n_recv, n_clamp);
		$display("over four handshake phases plus one long result-side hold.");
		if (errors == 0 && angles_due.size() == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end
endmodule
